// ===== rtl/jkve_pkg.sv =====
// Shared types and constants for the JSON key/value extractor.
// Holds beat structs, character classes and status codes; no dependencies.
`default_nettype none

package jkve_pkg;

  typedef struct packed {
    logic [7:0] doc_byte;
    logic       end_of_doc;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value_offset;
    logic [31:0] value_length;
  } out_item_t;

  typedef struct packed {
    logic [63:0] bytes_low;
    logic [63:0] bytes_high;
    logic [4:0]  length;
  } key_cfg_t;

  typedef struct packed {
    logic is_ws;
    logic is_quote;
    logic is_lbrace;
    logic is_rbrace;
    logic is_lbrack;
    logic is_rbrack;
    logic is_colon;
    logic is_comma;
  } char_class_t;

  typedef struct packed {
    logic [7:0]  doc_byte;
    logic        end_of_doc;
    char_class_t cls;
  } q_entry_t;

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  localparam logic [2:0] ST_FOUND   = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_UNTERM  = 3'd4;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.is_ws     = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    r.is_quote  = (c == CH_QUOTE);
    r.is_lbrace = (c == CH_LBRACE);
    r.is_rbrace = (c == CH_RBRACE);
    r.is_lbrack = (c == CH_LBRACK);
    r.is_rbrack = (c == CH_RBRACK);
    r.is_colon  = (c == CH_COLON);
    r.is_comma  = (c == CH_COMMA);
    return r;
  endfunction

  // bytes past the sixteenth held in the registers read as zero
  function automatic logic [7:0] key_byte(input key_cfg_t k, input logic [4:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (idx < 5'd8) begin
      r = k.bytes_low[8*idx[2:0] +: 8];
    end else if (idx < 5'd16) begin
      r = k.bytes_high[8*idx[2:0] +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jkve_front.sv =====
// Front end: accepts document beats, classifies each byte, queues them.
// Uses jkve_pkg; feeds jkve_back through a four-entry queue.
`default_nettype none

module jkve_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              doc_valid,
  output logic                   doc_stall,
  input  wire jkve_pkg::in_item_t doc,
  output logic                   head_valid,
  output jkve_pkg::q_entry_t     head,
  input  wire logic              pop
);
  import jkve_pkg::*;

  localparam int DEPTH = 4;

  q_entry_t   mem [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;

  assign doc_stall  = (count == 3'(DEPTH));
  assign push       = doc_valid && !doc_stall;
  assign head_valid = (count != 3'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{doc_byte: doc.doc_byte, end_of_doc: doc.end_of_doc,
                       cls: classify(doc.doc_byte)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (push && !pop) begin
        count <= count + 3'd1;
      end else if (pop && !push) begin
        count <= count - 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jkve_back.sv =====
// Back end: per-byte scan (balance counts, key window match, value phases)
// and the result register. Uses jkve_pkg; fed by jkve_front.
`default_nettype none

module jkve_back #(
  parameter int KEY_MAX    = 16,
  parameter int COUNT_BITS = 16,
  parameter int POS_BITS   = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire jkve_pkg::key_cfg_t key,
  input  wire logic               head_valid,
  input  wire jkve_pkg::q_entry_t head,
  output logic                    pop,
  output logic                    res_valid,
  output jkve_pkg::out_item_t     res,
  input  wire logic               res_stall
);
  import jkve_pkg::*;

  localparam int WIN = KEY_MAX + 2;
  localparam int FW  = $clog2(WIN + 1);

  typedef enum logic [2:0] {
    PH_SEARCH, PH_COLON, PH_PREVAL, PH_STRING, PH_NEST, PH_BARE, PH_DONE
  } phase_t;

  logic [7:0]            hist [WIN-1];
  logic [7:0]            win_new [WIN];
  logic [FW-1:0]         fill, fill_next;
  logic [POS_BITS-1:0]   pos, pos_next;
  logic [COUNT_BITS-1:0] brace_cnt, brace_cnt_next;
  logic [COUNT_BITS-1:0] brack_cnt, brack_cnt_next;
  logic [COUNT_BITS-1:0] nest_depth, nest_depth_next, depth_dec;
  logic                  nest_is_brace, nest_is_brace_next;
  logic                  doc_invalid, doc_invalid_next;
  phase_t                phase, phase_next;
  logic [POS_BITS-1:0]   vbegin, vbegin_next;
  logic [POS_BITS-1:0]   vend, vend_next;
  logic [2:0]            outcome, outcome_next;
  logic                  key_hit;
  logic                  nest_open, nest_close;
  logic [2:0]            status;
  logic [POS_BITS-1:0]   len;
  logic [POS_BITS+31:0]  off_ext, len_ext;
  out_item_t             result;

  assign pop = head_valid && (!head.end_of_doc || !res_valid || !res_stall);

  always_comb begin
    win_new[0] = head.doc_byte;
    for (int j = 1; j < WIN; j++) begin
      win_new[j] = hist[j-1];
    end
  end

  always_comb begin
    logic ok;
    ok = (int'(key.length) <= KEY_MAX) && win_new[0] == CH_QUOTE
         && (int'(fill_next) >= int'(key.length) + 2);
    for (int j = 1; j < WIN; j++) begin
      if (int'(key.length) + 1 == j && win_new[j] != CH_QUOTE) begin
        ok = 1'b0;
      end
    end
    for (int j = 1; j <= KEY_MAX; j++) begin
      if (j <= int'(key.length)
          && win_new[j] != key_byte(key, key.length - 5'(j))) begin
        ok = 1'b0;
      end
    end
    key_hit = ok;
  end

  assign fill_next  = (fill < FW'(WIN)) ? fill + 1'b1 : fill;
  assign depth_dec  = (nest_depth != '0) ? nest_depth - 1'b1 : nest_depth;
  assign nest_open  = nest_is_brace ? head.cls.is_lbrace : head.cls.is_lbrack;
  assign nest_close = nest_is_brace ? head.cls.is_rbrace : head.cls.is_rbrack;

  always_comb begin
    doc_invalid_next   = doc_invalid;
    pos_next           = pos;
    brace_cnt_next     = brace_cnt;
    brack_cnt_next     = brack_cnt;
    phase_next         = phase;
    vbegin_next        = vbegin;
    vend_next          = vend;
    nest_depth_next    = nest_depth;
    nest_is_brace_next = nest_is_brace;
    outcome_next       = outcome;

    if (&pos) begin
      doc_invalid_next = 1'b1;
    end else begin
      pos_next = pos + 1'b1;
    end

    if (head.cls.is_lbrace) begin
      if (&brace_cnt) doc_invalid_next = 1'b1;
      else brace_cnt_next = brace_cnt + 1'b1;
    end else if (head.cls.is_rbrace) begin
      if (brace_cnt == '0) doc_invalid_next = 1'b1;
      else brace_cnt_next = brace_cnt - 1'b1;
    end else if (head.cls.is_lbrack) begin
      if (&brack_cnt) doc_invalid_next = 1'b1;
      else brack_cnt_next = brack_cnt + 1'b1;
    end else if (head.cls.is_rbrack) begin
      if (brack_cnt == '0) doc_invalid_next = 1'b1;
      else brack_cnt_next = brack_cnt - 1'b1;
    end

    case (phase)
      PH_SEARCH: begin
        if (key_hit) phase_next = PH_COLON;
      end
      PH_COLON: begin
        if (head.cls.is_colon) begin
          phase_next = PH_PREVAL;
        end else if (!head.cls.is_ws) begin
          phase_next   = PH_DONE;
          outcome_next = ST_MISSING;
          vbegin_next  = '0;
          vend_next    = '0;
        end
      end
      PH_PREVAL: begin
        if (head.cls.is_ws) begin
          phase_next = PH_PREVAL;
        end else if (head.cls.is_quote) begin
          phase_next  = PH_STRING;
          vbegin_next = pos + 1'b1;
        end else if (head.cls.is_lbrace || head.cls.is_lbrack) begin
          phase_next         = PH_NEST;
          vbegin_next        = pos;
          nest_depth_next    = COUNT_BITS'(1);
          nest_is_brace_next = head.cls.is_lbrace;
        end else if (head.cls.is_comma || head.cls.is_rbrace || head.cls.is_rbrack) begin
          phase_next   = PH_DONE;
          outcome_next = ST_FOUND;
          vbegin_next  = pos;
          vend_next    = pos;
        end else begin
          phase_next  = PH_BARE;
          vbegin_next = pos;
        end
      end
      PH_STRING: begin
        if (head.cls.is_quote) begin
          phase_next   = PH_DONE;
          outcome_next = ST_FOUND;
          vend_next    = pos;
        end
      end
      PH_NEST: begin
        if (nest_open) begin
          if (!(&nest_depth)) nest_depth_next = nest_depth + 1'b1;
        end else if (nest_close) begin
          nest_depth_next = depth_dec;
          if (depth_dec == '0) begin
            phase_next   = PH_DONE;
            outcome_next = ST_FOUND;
            vend_next    = pos + 1'b1;
          end
        end
      end
      PH_BARE: begin
        if (head.cls.is_comma || head.cls.is_rbrace || head.cls.is_rbrack
            || head.cls.is_ws) begin
          phase_next   = PH_DONE;
          outcome_next = ST_FOUND;
          vend_next    = pos;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // bare value running into the final byte
    if (head.end_of_doc && phase_next == PH_BARE) begin
      phase_next   = PH_DONE;
      outcome_next = ST_FOUND;
      vend_next    = pos + 1'b1;
    end
  end

  always_comb begin
    if (doc_invalid_next || brace_cnt_next != '0 || brack_cnt_next != '0) begin
      status = ST_INVALID;
    end else begin
      case (phase_next)
        PH_DONE:   status = outcome_next;
        PH_SEARCH: status = ST_ABSENT;
        PH_COLON:  status = ST_MISSING;
        PH_PREVAL: status = ST_MISSING;
        default:   status = ST_UNTERM;
      endcase
    end
  end

  assign len     = vend_next - vbegin_next;
  assign off_ext = {32'd0, vbegin_next};
  assign len_ext = {32'd0, len};

  always_comb begin
    result.status = status;
    if (status == ST_FOUND && vend_next >= vbegin_next) begin
      result.value_offset = off_ext[31:0];
      result.value_length = len_ext[31:0];
    end else begin
      result.value_offset = '0;
      result.value_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < WIN - 1; j++) hist[j] <= '0;
      fill          <= '0;
      pos           <= '0;
      brace_cnt     <= '0;
      brack_cnt     <= '0;
      nest_depth    <= '0;
      nest_is_brace <= 1'b0;
      doc_invalid   <= 1'b0;
      phase         <= PH_SEARCH;
      vbegin        <= '0;
      vend          <= '0;
      outcome       <= ST_ABSENT;
      res_valid     <= 1'b0;
    end else begin
      if (pop && head.end_of_doc) begin
        for (int j = 0; j < WIN - 1; j++) hist[j] <= '0;
        fill          <= '0;
        pos           <= '0;
        brace_cnt     <= '0;
        brack_cnt     <= '0;
        nest_depth    <= '0;
        nest_is_brace <= 1'b0;
        doc_invalid   <= 1'b0;
        phase         <= PH_SEARCH;
        vbegin        <= '0;
        vend          <= '0;
        outcome       <= ST_ABSENT;
      end else if (pop) begin
        for (int j = 0; j < WIN - 1; j++) hist[j] <= win_new[j];
        fill          <= fill_next;
        pos           <= pos_next;
        brace_cnt     <= brace_cnt_next;
        brack_cnt     <= brack_cnt_next;
        nest_depth    <= nest_depth_next;
        nest_is_brace <= nest_is_brace_next;
        doc_invalid   <= doc_invalid_next;
        phase         <= phase_next;
        vbegin        <= vbegin_next;
        vend          <= vend_next;
        outcome       <= outcome_next;
      end
      if (pop && head.end_of_doc) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.end_of_doc) begin
      res <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/json_key_value_extractor_top.sv =====
// Top level of the JSON key/value extractor: key registers, front queue
// and back-end scanner. Uses jkve_pkg, jkve_front and jkve_back.
`default_nettype none

// Streams a document one byte per beat and sustains one byte per clock while
// no final byte waits behind a result held on res_stall: the back end retires
// one queued byte each cycle, its per-byte step (balance counts, parallel
// key-window compare, value tracking) being the limit. The single result beat
// appears on res at the clock edge that takes the final byte out of the queue.
// A four-entry queue and the result register let the input keep flowing while
// a result waits on res_stall. Key registers are written by the user through
// cfg_we/cfg_index/cfg_data only between documents; the block does not enforce it.
module json_key_value_extractor_top #(
  parameter int KEY_MAX    = 16,
  parameter int COUNT_BITS = 16,
  parameter int POS_BITS   = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                doc_valid,
  output logic                     doc_stall,
  input  wire jkve_pkg::in_item_t  doc,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output jkve_pkg::out_item_t      res,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);
  import jkve_pkg::*;

  key_cfg_t key;
  logic     head_valid;
  q_entry_t head;
  logic     pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LOW:  key.bytes_low  <= cfg_data;
        REG_KEY_HIGH: key.bytes_high <= cfg_data;
        REG_KEY_LEN:  key.length     <= cfg_data[4:0];
        default:      key.length     <= key.length;
      endcase
    end
  end

  jkve_front u_front (
    .clk        (clk),
    .rst        (rst),
    .doc_valid  (doc_valid),
    .doc_stall  (doc_stall),
    .doc        (doc),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  jkve_back #(
    .KEY_MAX    (KEY_MAX),
    .COUNT_BITS (COUNT_BITS),
    .POS_BITS   (POS_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_stall  (res_stall)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_no_stall_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !doc_stall)
    else $error("input stalled right after reset");

  a_clean_miss: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_FOUND |->
      res.value_offset == 32'd0 && res.value_length == 32'd0)
    else $error("nonzero span on a miss");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pop) && $past(head.end_of_doc))
    else $error("result without a final byte");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for json_key_value_extractor_top: streams directed and random documents,
// predicts each per-document report in a scoreboard class and compares every result beat.
// Depends on jkve_pkg for the beat structs, register indexes, status codes and characters.

module tb_top;
  import jkve_pkg::*;

  localparam int        KEY_MAX     = 16;
  localparam int        WIN         = KEY_MAX + 2;
  localparam bit [15:0] CNT_MAX     = 16'hFFFF;
  localparam bit [32:0] POS_MAX     = 33'h0_FFFF_FFFF;
  localparam int        QUIET_LIMIT = 4000;

  typedef bit [7:0] text_t[$];

  typedef enum logic [2:0] {
    SEEK_KEY, SEEK_COLON, SEEK_VALUE, IN_STRING, IN_NEST, IN_BARE, VALUE_DONE
  } scan_t;

  class locate_scoreboard;
    bit [63:0] key_lo, key_hi;
    bit [4:0]  key_len;
    bit [7:0]  window [WIN];
    bit [32:0] pos, vbeg, vend;
    bit [15:0] braces, bracks, depth;
    bit        bad, nest_brace;
    scan_t     phase;
    bit [2:0]  outcome;
    out_item_t pending_reports[$];
    int        mismatches, reports, docs, bytes_seen;
    int        by_status[8];

    function void clear_doc();
      foreach (window[i]) window[i] = 8'h00;
      pos = 0; vbeg = 0; vend = 0;
      braces = 0; bracks = 0; depth = 0;
      bad = 1'b0; nest_brace = 1'b0;
      phase = SEEK_KEY;
      outcome = ST_ABSENT;
    endfunction

    function bit is_space(bit [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit [7:0] key_char(int i);
      if (i < 8) return key_lo[8*i +: 8];
      if (i < 16) return key_hi[8*(i-8) +: 8];
      return 8'h00;
    endfunction

    // quoted key must sit wholly inside the current document
    function bit key_here(bit [32:0] p);
      int total, i;
      if (key_len > KEY_MAX) return 1'b0;
      total = key_len + 2;
      if (p + 1 < total) return 1'b0;
      if (window[0] != CH_QUOTE || window[total-1] != CH_QUOTE) return 1'b0;
      for (i = 0; i < key_len; i++)
        if (window[total-2-i] != key_char(i)) return 1'b0;
      return 1'b1;
    endfunction

    function void set_outcome(bit [2:0] code, bit [32:0] b, bit [32:0] e);
      phase = VALUE_DONE;
      outcome = code;
      vbeg = b;
      vend = e;
    endfunction

    function void predict_byte(in_item_t b);
      bit [7:0]  c, opener, closer;
      bit [32:0] p, span;
      bit [2:0]  st;
      out_item_t r;
      int        i;
      c = b.doc_byte;
      p = pos;
      bytes_seen++;
      if (pos >= POS_MAX) bad = 1'b1;
      else pos = pos + 1;
      for (i = WIN - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = c;

      if (c == CH_LBRACE) begin
        if (braces == CNT_MAX) bad = 1'b1; else braces++;
      end else if (c == CH_RBRACE) begin
        if (braces == 0) bad = 1'b1; else braces--;
      end else if (c == CH_LBRACK) begin
        if (bracks == CNT_MAX) bad = 1'b1; else bracks++;
      end else if (c == CH_RBRACK) begin
        if (bracks == 0) bad = 1'b1; else bracks--;
      end

      case (phase)
        SEEK_KEY: begin
          if (key_here(p)) phase = SEEK_COLON;
        end
        SEEK_COLON: begin
          if (c == CH_COLON) phase = SEEK_VALUE;
          else if (!is_space(c)) set_outcome(ST_MISSING, 0, 0);
        end
        SEEK_VALUE: begin
          if (!is_space(c)) begin
            if (c == CH_QUOTE) begin
              phase = IN_STRING;
              vbeg = p + 1;
            end else if (c == CH_LBRACE || c == CH_LBRACK) begin
              phase = IN_NEST;
              vbeg = p;
              depth = 1;
              nest_brace = (c == CH_LBRACE);
            end else if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK) begin
              set_outcome(ST_FOUND, p, p);
            end else begin
              phase = IN_BARE;
              vbeg = p;
            end
          end
        end
        IN_STRING: begin
          if (c == CH_QUOTE) set_outcome(ST_FOUND, vbeg, p);
        end
        IN_NEST: begin
          // only the opener's own bracket type is counted
          opener = nest_brace ? CH_LBRACE : CH_LBRACK;
          closer = nest_brace ? CH_RBRACE : CH_RBRACK;
          if (c == opener) begin
            if (depth != CNT_MAX) depth++;
          end else if (c == closer) begin
            if (depth != 0) depth--;
            if (depth == 0) set_outcome(ST_FOUND, vbeg, p + 1);
          end
        end
        IN_BARE: begin
          if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK || is_space(c))
            set_outcome(ST_FOUND, vbeg, p);
        end
        default: ;
      endcase

      if (!b.end_of_doc) return;

      if (phase == IN_BARE) set_outcome(ST_FOUND, vbeg, p + 1);
      if (bad || braces != 0 || bracks != 0) st = ST_INVALID;
      else if (phase == VALUE_DONE) st = outcome;
      else if (phase == SEEK_KEY) st = ST_ABSENT;
      else if (phase == SEEK_COLON || phase == SEEK_VALUE) st = ST_MISSING;
      else st = ST_UNTERM;

      r = '0;
      r.status = st;
      if (st == ST_FOUND && vend >= vbeg) begin
        span = vend - vbeg;
        r.value_offset = vbeg[31:0];
        r.value_length = span[31:0];
      end
      pending_reports.push_back(r);
      by_status[st]++;
      docs++;
      clear_doc();
    endfunction

    task flag(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_report(out_item_t got);
      out_item_t want;
      reports++;
      if (pending_reports.size() == 0) begin
        flag($sformatf("report %0d arrived with no document pending", reports));
        return;
      end
      want = pending_reports.pop_front();
      if (got.status !== want.status)
        flag($sformatf("report %0d status %0d, predicted %0d",
                       reports, got.status, want.status));
      if (got.value_offset !== want.value_offset)
        flag($sformatf("report %0d value_offset %0d, predicted %0d",
                       reports, got.value_offset, want.value_offset));
      if (got.value_length !== want.value_length)
        flag($sformatf("report %0d value_length %0d, predicted %0d",
                       reports, got.value_length, want.value_length));
    endtask
  endclass

  logic        clk, rst;
  logic        doc_valid, doc_stall;
  in_item_t    doc;
  logic        res_valid, res_stall;
  out_item_t   res;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  locate_scoreboard sb;
  int src_idle, sink_stall;
  int quiet;

  json_key_value_extractor_top dut (
    .clk, .rst, .doc_valid, .doc_stall, .doc, .res_valid, .res_stall, .res,
    .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    res_stall = ($urandom_range(99) < sink_stall);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_report(res);
  end

  always @(posedge clk) begin
    if (rst || (doc_valid && !doc_stall) || (res_valid && !res_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", quiet);
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic bit [7:0] letter();
    return 8'($urandom_range(25) + 97);
  endfunction

  function automatic bit [7:0] ws_char();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return 8'h0A;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  // structural characters, whitespace neighbors and byte extremes
  function automatic bit [7:0] odd_char();
    case ($urandom_range(13))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_LBRACK;
      3: return CH_RBRACK;
      4: return CH_COLON;
      5: return CH_COMMA;
      6: return CH_QUOTE;
      7: return ws_char();
      8: return 8'h08;
      9: return 8'h0E;
      10: return 8'h00;
      11: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic bit [7:0] text_char();
    bit [7:0] r;
    if ($urandom_range(9) == 0) begin
      r = odd_char();
      if (r == CH_QUOTE) r = letter();
    end else if ($urandom_range(3) == 0) begin
      r = 8'($urandom_range(9) + 48);
    end else begin
      r = letter();
    end
    return r;
  endfunction

  function automatic logic [63:0] letters8();
    logic [63:0] r;
    int i;
    for (i = 0; i < 8; i++) r[8*i +: 8] = letter();
    return r;
  endfunction

  task automatic put_str(ref text_t t, input string s);
    int i;
    for (i = 0; i < s.len(); i++) t.push_back(s[i]);
  endtask

  task automatic add_ws(ref text_t t);
    if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) t.push_back(ws_char());
  endtask

  task automatic add_key(ref text_t t);
    int i;
    t.push_back(CH_QUOTE);
    for (i = 0; i < sb.key_len; i++) t.push_back(sb.key_char(i));
    t.push_back(CH_QUOTE);
  endtask

  task automatic add_name(ref text_t t);
    t.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 3)) t.push_back(letter());
    t.push_back(CH_QUOTE);
  endtask

  task automatic add_pair(ref text_t t, input int lvl, input bit target);
    add_ws(t);
    if (target) add_key(t);
    else add_name(t);
    add_ws(t);
    t.push_back(CH_COLON);
    add_ws(t);
    add_value(t, lvl);
    add_ws(t);
  endtask

  task automatic add_value(ref text_t t, input int lvl);
    int kind, n, i;
    kind = (lvl >= 3) ? $urandom_range(3) : $urandom_range(5);
    case (kind)
      0: begin
        t.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 5)) t.push_back(text_char());
        t.push_back(CH_QUOTE);
      end
      1: begin
        if ($urandom_range(3) == 0) t.push_back(8'h2D);
        repeat ($urandom_range(1, 4)) t.push_back(8'($urandom_range(9) + 48));
      end
      2: put_str(t, $urandom_range(1) ? "true" : "null");
      3: ;
      4: begin
        t.push_back(CH_LBRACE);
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) begin
          if (i > 0) t.push_back(CH_COMMA);
          add_pair(t, lvl + 1, $urandom_range(5) == 0);
        end
        add_ws(t);
        t.push_back(CH_RBRACE);
      end
      default: begin
        t.push_back(CH_LBRACK);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
          if (i > 0) t.push_back(CH_COMMA);
          add_ws(t);
          add_value(t, lvl + 1);
        end
        t.push_back(CH_RBRACK);
      end
    endcase
  endtask

  task automatic make_doc(ref text_t t);
    int n, hit, i;
    if ($urandom_range(5) == 0) begin
      add_ws(t);
      add_key(t);
      add_ws(t);
      if ($urandom_range(9) != 0) begin
        t.push_back(CH_COLON);
        add_ws(t);
        add_value(t, 1);
      end
    end else begin
      n = $urandom_range(1, 3);
      hit = $urandom_range(0, n);
      t.push_back(CH_LBRACE);
      for (i = 0; i < n; i++) begin
        if (i > 0) t.push_back(CH_COMMA);
        add_pair(t, 1, i == hit || $urandom_range(7) == 0);
      end
      add_ws(t);
      t.push_back(CH_RBRACE);
    end
  endtask

  task automatic random_doc(ref text_t t);
    int pick, k, i;
    pick = $urandom_range(99);
    if (pick < 85) begin
      make_doc(t);
      if (pick >= 70) begin
        k = $urandom_range(3);
        i = $urandom_range(0, t.size() - 1);
        case (k)
          0: t = t[0:i];
          1: t[i] = odd_char();
          2: if (t.size() > 1) t.delete(i);
          default: t.insert(i, odd_char());
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 12)) t.push_back(odd_char());
    end
  endtask

  task automatic send_beat(input in_item_t b);
    while ($urandom_range(99) < src_idle) begin
      doc_valid = 1'b0;
      @(negedge clk);
    end
    doc = b;
    doc_valid = 1'b1;
    @(posedge clk);
    while (doc_stall) @(posedge clk);
    sb.predict_byte(b);
    @(negedge clk);
  endtask

  task automatic send_doc(input text_t t);
    in_item_t b;
    int i;
    for (i = 0; i < t.size(); i++) begin
      b.doc_byte = t[i];
      b.end_of_doc = (i == t.size() - 1);
      send_beat(b);
    end
    doc_valid = 1'b0;
  endtask

  task automatic send_text(input string s);
    text_t t;
    put_str(t, s);
    send_doc(t);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_KEY_LOW:  sb.key_lo = val;
      REG_KEY_HIGH: sb.key_hi = val;
      REG_KEY_LEN:  sb.key_len = val[4:0];
      default: ;
    endcase
  endtask

  // block is idle once every report is back and the pipe has drained
  task automatic settle();
    while (sb.pending_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [4:0] len, input int src, input int sink,
                           input int budget);
    text_t t;
    int sent;
    settle();
    write_reg(REG_KEY_LOW, lo);
    write_reg(REG_KEY_HIGH, hi);
    write_reg(REG_KEY_LEN, {59'd0, len});
    src_idle = src;
    sink_stall = sink;
    sent = 0;
    while (sent < budget) begin
      t = {};
      random_doc(t);
      send_doc(t);
      sent += t.size();
    end
  endtask

  initial begin
    text_t t;
    sb = new();
    sb.clear_doc();
    rst = 1'b1;
    doc_valid = 1'b0;
    doc = '0;
    res_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_KEY_LOW;
    cfg_data = '0;
    src_idle = 0;
    sink_stall = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // key "k"
    run_phase(64'h6B, 64'd0, 5'd1, 0, 0, 0);
    send_text("\"k\":7");
    send_text("{\"k\":\"ab\"}");
    send_text("{\"k\" : \t {\"a\":{}} }");
    send_text("{\"k\":[1,[2],{\"b\":3}]}");
    send_text("{\"k\":,\"a\":1}");
    send_text("{\"k\":}");
    send_text("\"k\":]");
    send_text("{\"k\" \n}");
    send_text("\"k\":");
    send_text("\"k\" ");
    send_text("\"k\":\"ab");
    send_text("{\"k\":[1,2}");
    send_text("}{");
    send_text("{\"a\":1}");
    send_text("{\"xk\":1,\"k\":true}");
    send_text("{\"k\":\"a\",\"k\":\"b\"}");
    send_text("\"");
    send_text("k\":1");
    send_text("\"k\": 12 ");
    send_text("[{\"k\":[[]],\"z\":[]}]");
    send_text("{\"k\":{\"a\":[}]}");
    send_text("{\"k\":x}");
    t = {};
    t.push_back(8'h00);
    t.push_back(8'hFF);
    send_doc(t);

    run_phase('1, '1, 5'd0, 61, 0, 190);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 0, 61, 190);
    run_phase('1, 64'd0, 5'd16, 16, 16, 190);
    run_phase(64'd0, '1, 5'd31, 0, 0, 180);
    run_phase(letters8(), letters8(), 5'd17, 61, 0, 180);
    run_phase(letters8(), letters8(), 5'($urandom_range(1, 15)), 0, 61, 190);
    run_phase(letters8(), letters8(), 5'($urandom_range(1, 6)), 16, 16, 190);
    run_phase(64'h6B, 64'd0, 5'd1, 16, 16, 100);

    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d documents, %0d bytes, 9 key settings, 4 flow-control mixes",
             sb.docs, sb.bytes_seen);
    $display("reports %0d: found %0d invalid %0d absent %0d missing %0d unterminated %0d",
             sb.reports, sb.by_status[ST_FOUND], sb.by_status[ST_INVALID],
             sb.by_status[ST_ABSENT], sb.by_status[ST_MISSING], sb.by_status[ST_UNTERM]);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
